// File: rtl/pcds_pkg.sv
`timescale 1ns / 1ps

package pcds_pkg;

    localparam int RATE_W   = 32;
    localparam int WIDE_W   = 34;
    localparam int DIVR_W   = 8;
    localparam int FD_W     = 6;
    localparam int FACTOR_W = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [DIVR_W-1:0] DIV_LIMIT = 8'd255;
    localparam logic [DIVR_W-1:0] PMIN_TFT  = 8'd2;
    localparam logic [DIVR_W-1:0] PMIN_STN  = 8'd3;

    localparam logic [1:0] REG_PARENT_RATE = 2'd0;
    localparam logic [1:0] REG_MAX_FUNC    = 2'd1;
    localparam logic [1:0] REG_FD_MAX      = 2'd2;
    localparam logic [1:0] REG_FD_FACTOR   = 2'd3;

    localparam logic [RATE_W-1:0]   RST_PARENT_RATE = 32'd864000000;
    localparam logic [RATE_W-1:0]   RST_MAX_FUNC    = 32'd173000000;
    localparam logic [FD_W-1:0]     RST_FD_MAX      = 6'd16;
    localparam logic [FACTOR_W-1:0] RST_FD_FACTOR   = 2'd1;

    typedef struct packed {
        logic [RATE_W-1:0]   parent_rate;
        logic [RATE_W-1:0]   max_func_clock;
        logic [FD_W-1:0]     func_div_max;
        logic [FACTOR_W-1:0] func_div_factor;
    } cfg_t;

    typedef struct packed {
        logic [RATE_W-1:0] req_clock;
        logic              is_tft;
    } in_t;

    typedef struct packed {
        logic [DIVR_W-1:0] logic_div;
        logic [DIVR_W-1:0] pixel_div;
        logic [FD_W-1:0]   func_div;
        logic [RATE_W-1:0] achieved_clock;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/pcds_div.sv
`timescale 1ns / 1ps

module pcds_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcds_pkg::div_req_t  div_req,
    output pcds_pkg::div_rsp_t  div_rsp
);
    import pcds_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W + 1);

    logic [WIDE_W-1:0] quot_reg, quot_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   trial_sub;
    logic              ge;

    // one quotient bit a cycle, restoring
    assign trial     = {rem_reg, quot_reg[WIDE_W-1]};
    assign ge        = trial >= {1'b0, dvsr_reg};
    assign trial_sub = trial - {1'b0, dvsr_reg};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (div_req.start) begin
            quot_next = div_req.dividend;
            rem_next  = '0;
            dvsr_next = div_req.divisor;
            cnt_next  = CNT_W'(WIDE_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[WIDE_W-2:0], ge};
            rem_next  = ge ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quot_reg;

endmodule

// File: rtl/pcds_seq.sv
`timescale 1ns / 1ps

module pcds_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  pcds_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  pcds_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pcds_pkg::out_t  m_data
);
    import pcds_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_GO   = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_FCHK     = 4'd3;
    localparam logic [3:0] S_PEVAL    = 4'd4;
    localparam logic [3:0] S_IEND     = 4'd5;
    localparam logic [3:0] S_NEXTF    = 4'd6;
    localparam logic [3:0] S_FINISH   = 4'd7;

    localparam logic [1:0] K_FUNC  = 2'd0;
    localparam logic [1:0] K_LOGIC = 2'd1;
    localparam logic [1:0] K_PIX   = 2'd2;
    localparam logic [1:0] K_LCHK  = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [RATE_W-1:0] req_reg, req_next;
    logic [DIVR_W-1:0] pmin_reg, pmin_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic [DIVR_W-1:0] ld_reg, ld_next;
    logic [DIVR_W-1:0] pd_reg, pd_next;
    logic [WIDE_W-1:0] fck_reg, fck_next;
    logic [WIDE_W-1:0] lck_reg, lck_next;
    logic [WIDE_W-1:0] pck_reg, pck_next;
    logic              have_reg, have_next;
    logic [WIDE_W-1:0] ib_pck_reg, ib_pck_next;
    logic [WIDE_W-1:0] ib_diff_reg, ib_diff_next;
    logic [DIVR_W-1:0] ib_ld_reg, ib_ld_next;
    logic [DIVR_W-1:0] ib_pd_reg, ib_pd_next;
    logic [WIDE_W-1:0] ob_pck_reg, ob_pck_next;
    logic [WIDE_W-1:0] ob_diff_reg, ob_diff_next;
    logic [DIVR_W-1:0] ob_ld_reg, ob_ld_next;
    logic [DIVR_W-1:0] ob_pd_reg, ob_pd_next;
    logic [FD_W-1:0]   ob_fd_reg, ob_fd_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [WIDE_W-1:0] req_wide;
    logic [WIDE_W-1:0] q_narrow;
    logic [WIDE_W-1:0] fck_calc;
    logic [WIDE_W-1:0] pck_diff;

    pcds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign req_wide = {2'b00, req_reg};
    assign q_narrow = {2'b00, div_rsp.quotient[RATE_W-1:0]};
    assign fck_calc = (q_narrow & {WIDE_W{cfg.func_div_factor[0]}})
                    + ({q_narrow[WIDE_W-2:0], 1'b0} & {WIDE_W{cfg.func_div_factor[1]}});
    assign pck_diff = (pck_reg >= req_wide) ? (pck_reg - req_wide) : (req_wide - pck_reg);

    always_comb begin
        div_req.start = (state_reg == S_DIV_GO);
        case (kind_reg)
            K_FUNC: begin
                div_req.dividend = {2'b00, cfg.parent_rate};
                div_req.divisor  = {2'b00, fd_reg};
            end
            K_LOGIC: begin
                div_req.dividend = fck_reg;
                div_req.divisor  = ld_reg;
            end
            K_PIX: begin
                div_req.dividend = lck_reg;
                div_req.divisor  = pd_reg;
            end
            default: begin
                div_req.dividend = lck_reg;
                div_req.divisor  = pmin_reg;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        req_next     = req_reg;
        pmin_next    = pmin_reg;
        fd_next      = fd_reg;
        ld_next      = ld_reg;
        pd_next      = pd_reg;
        fck_next     = fck_reg;
        lck_next     = lck_reg;
        pck_next     = pck_reg;
        have_next    = have_reg;
        ib_pck_next  = ib_pck_reg;
        ib_diff_next = ib_diff_reg;
        ib_ld_next   = ib_ld_reg;
        ib_pd_next   = ib_pd_reg;
        ob_pck_next  = ob_pck_reg;
        ob_diff_next = ob_diff_reg;
        ob_ld_next   = ob_ld_reg;
        ob_pd_next   = ob_pd_reg;
        ob_fd_next   = ob_fd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data.req_clock;
                    pmin_next    = s_data.is_tft ? PMIN_TFT : PMIN_STN;
                    fd_next      = cfg.func_div_max;
                    ob_pck_next  = '0;
                    ob_diff_next = {2'b00, s_data.req_clock};
                    ob_ld_next   = '0;
                    ob_pd_next   = '0;
                    ob_fd_next   = '0;
                    kind_next    = K_FUNC;
                    state_next   = (cfg.func_div_max == '0) ? S_FINISH : S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (kind_reg)
                        K_FUNC: begin
                            fck_next   = fck_calc;
                            state_next = S_FCHK;
                        end
                        K_LOGIC: begin
                            lck_next   = div_rsp.quotient;
                            pd_next    = pmin_reg;
                            kind_next  = K_PIX;
                            state_next = S_DIV_GO;
                        end
                        K_PIX: begin
                            pck_next   = div_rsp.quotient;
                            state_next = S_PEVAL;
                        end
                        default: begin
                            // logic loop stops at limit or when min pixel divider undershoots
                            if (div_rsp.quotient < req_wide || ld_reg == DIV_LIMIT) begin
                                state_next = S_IEND;
                            end else begin
                                ld_next    = ld_reg + 1'b1;
                                kind_next  = K_LOGIC;
                                state_next = S_DIV_GO;
                            end
                        end
                    endcase
                end
            end
            S_FCHK: begin
                if (fck_reg > {2'b00, cfg.max_func_clock} || fck_reg < req_wide) begin
                    state_next = S_NEXTF;
                end else begin
                    ld_next    = DIVR_W'(1);
                    have_next  = 1'b0;
                    kind_next  = K_LOGIC;
                    state_next = S_DIV_GO;
                end
            end
            S_PEVAL: begin
                if (!have_reg || pck_diff < ib_diff_reg) begin
                    have_next    = 1'b1;
                    ib_pck_next  = pck_reg;
                    ib_diff_next = pck_diff;
                    ib_ld_next   = ld_reg;
                    ib_pd_next   = pd_reg;
                end
                if ((!have_reg || pck_diff < ib_diff_reg) && pck_reg == req_wide) begin
                    state_next = S_IEND;
                end else if (pck_reg < req_wide || pd_reg == DIV_LIMIT) begin
                    kind_next  = K_LCHK;
                    state_next = S_DIV_GO;
                end else begin
                    pd_next    = pd_reg + 1'b1;
                    kind_next  = K_PIX;
                    state_next = S_DIV_GO;
                end
            end
            S_IEND: begin
                if (ib_diff_reg < ob_diff_reg) begin
                    ob_pck_next  = ib_pck_reg;
                    ob_diff_next = ib_diff_reg;
                    ob_ld_next   = ib_ld_reg;
                    ob_pd_next   = ib_pd_reg;
                    ob_fd_next   = fd_reg;
                end
                // exact hit ends the outer search
                if (ib_diff_reg < ob_diff_reg && ib_diff_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_NEXTF;
                end
            end
            S_NEXTF: begin
                if (fd_reg == FD_W'(1)) begin
                    state_next = S_FINISH;
                end else begin
                    fd_next    = fd_reg - 1'b1;
                    kind_next  = K_FUNC;
                    state_next = S_DIV_GO;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.logic_div       = ob_ld_reg;
                    m_data_next.pixel_div       = ob_pd_reg;
                    m_data_next.func_div        = ob_fd_reg;
                    m_data_next.achieved_clock  = ob_pck_reg[RATE_W-1:0];
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            kind_reg    <= K_FUNC;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg     <= req_next;
        pmin_reg    <= pmin_next;
        fd_reg      <= fd_next;
        ld_reg      <= ld_next;
        pd_reg      <= pd_next;
        fck_reg     <= fck_next;
        lck_reg     <= lck_next;
        pck_reg     <= pck_next;
        ib_pck_reg  <= ib_pck_next;
        ib_diff_reg <= ib_diff_next;
        ib_ld_reg   <= ib_ld_next;
        ib_pd_reg   <= ib_pd_next;
        ob_pck_reg  <= ob_pck_next;
        ob_diff_reg <= ob_diff_next;
        ob_ld_reg   <= ob_ld_next;
        ob_pd_reg   <= ob_pd_next;
        ob_fd_reg   <= ob_fd_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/pixel_clock_divider_search_core.sv
`timescale 1ns / 1ps

// Pixel clock divider search.
// Input word (s_valid/s_ready/s_data): requested pixel clock in Hz and a TFT flag.
// Result word (m_valid/m_ready/m_data): logic, pixel and functional dividers and the
// pixel clock they give; one result per input word, all zero when nothing qualifies.
// Configuration over the APB port: parent rate, functional clock ceiling, first
// functional divider and post-divide factor at byte offsets 0x0, 0x4, 0x8, 0xC.
// One input word is taken at a time. All divisions go through one shared restoring
// divider that produces one quotient bit a cycle. There is one division per
// functional divider tried, one per logic divider, one per pixel divider evaluated
// and one early-exit check per logic divider whose pixel search ends without an
// exact hit. The next word is accepted once a result has been formed, even while
// that result still waits in the output register; if the receiver stalls, a second
// finished result holds in the search engine until the output register is taken.
// Reset (synchronous, active low) returns the registers to their defaults and
// drops any word in flight.
module pixel_clock_divider_search_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcds_pkg::ADDR_W-1:0]       paddr,
    input  logic [pcds_pkg::DATA_W-1:0]       pwdata,
    output logic [pcds_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pcds_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pcds_pkg::out_t                    m_data
);
    import pcds_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PARENT_RATE: cfg_next.parent_rate     = pwdata[RATE_W-1:0];
                REG_MAX_FUNC:    cfg_next.max_func_clock  = pwdata[RATE_W-1:0];
                REG_FD_MAX:      cfg_next.func_div_max    = pwdata[FD_W-1:0];
                REG_FD_FACTOR:   cfg_next.func_div_factor = pwdata[FACTOR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PARENT_RATE: prdata = cfg_reg.parent_rate;
            REG_MAX_FUNC:    prdata = cfg_reg.max_func_clock;
            REG_FD_MAX:      prdata = {{(DATA_W-FD_W){1'b0}}, cfg_reg.func_div_max};
            REG_FD_FACTOR:   prdata = {{(DATA_W-FACTOR_W){1'b0}}, cfg_reg.func_div_factor};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.parent_rate     <= RST_PARENT_RATE;
            cfg_reg.max_func_clock  <= RST_MAX_FUNC;
            cfg_reg.func_div_max    <= RST_FD_MAX;
            cfg_reg.func_div_factor <= RST_FD_FACTOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pcds_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // the search engine is busy in the cycle after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while search still running");

    // a chosen functional divider always comes with a pixel divider, and none without
    a_zero_result_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.func_div == '0) == (m_data.pixel_div == '0)))
        else $error("divider fields of result disagree");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result word present straight after reset");
`endif

endmodule
